// File: rtl/two_class_priority_stack_defines.svh
// Assertion macros shared by the two-class priority stack RTL.
`ifndef TWO_CLASS_PRIORITY_STACK_DEFINES_SVH
`define TWO_CLASS_PRIORITY_STACK_DEFINES_SVH
`ifndef SYNTHESIS
// Clocked check that is switched off while reset is asserted.
`define TCPS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Clocked check that also holds during reset.
`define TCPS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define TCPS_ASSERT(lbl, prop, msg)
`define TCPS_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// File: rtl/tcps_pkg.sv
// Shared types and constants of the two-class priority stack.
`timescale 1ns / 1ps
package tcps_pkg;

    localparam int DEPTH_DEF         = 16;
    localparam int KEY_WIDTH_DEF     = 32;
    localparam int PAYLOAD_WIDTH_DEF = 32;
    localparam int OP_W              = 3;
    localparam int DROP_W            = 5;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH        = 3'd0,
        OP_CLASS_PUSH  = 3'd1,
        OP_POP         = 3'd2,
        OP_DROP_BOTTOM = 3'd3,
        OP_DROP_COUNT  = 3'd4,
        OP_FIND        = 3'd5
    } op_e_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_PUSH,
        CELL_INSERT,
        CELL_SHIFT_DOWN
    } cell_cmd_t;

    // Per-cell control: the broadcast command plus the position flags of that cell.
    typedef struct packed {
        cell_cmd_t cmd;
        logic      occ;        // cell holds a live entry
        logic      at_fill;    // cell is the first free slot
        logic      low_occ;    // cell below holds a live entry
        logic      sfx_self;   // an ordinary entry sits at this slot or above
        logic      sfx_below;  // an ordinary entry sits at the slot below or above
    } cell_ctrl_t;

endpackage

// File: rtl/tcps_cell.sv
// One stack slot: holds an entry and trades it with its neighbors.
`timescale 1ns / 1ps
module tcps_cell #(
    parameter int KEY_WIDTH     = tcps_pkg::KEY_WIDTH_DEF,
    parameter int PAYLOAD_WIDTH = tcps_pkg::PAYLOAD_WIDTH_DEF
) (
    input  logic                     clk,
    input  tcps_pkg::cell_ctrl_t     ctrl,
    input  logic [KEY_WIDTH-1:0]     new_key,
    input  logic [PAYLOAD_WIDTH-1:0] new_payload,
    input  logic                     new_pri,
    input  logic [KEY_WIDTH-1:0]     below_key,
    input  logic [PAYLOAD_WIDTH-1:0] below_payload,
    input  logic                     below_pri,
    input  logic [KEY_WIDTH-1:0]     above_key,
    input  logic [PAYLOAD_WIDTH-1:0] above_payload,
    input  logic                     above_pri,
    output logic [KEY_WIDTH-1:0]     key,
    output logic [PAYLOAD_WIDTH-1:0] payload,
    output logic                     pri,
    output logic [KEY_WIDTH-1:0]     key_next,
    output logic [PAYLOAD_WIDTH-1:0] payload_next,
    output logic                     pri_next,
    output logic                     np,
    output logic                     hit
);

    logic [KEY_WIDTH-1:0]     key_reg;
    logic [PAYLOAD_WIDTH-1:0] payload_reg;
    logic                     pri_reg;

    always_comb
    begin
        key_next     = key_reg;
        payload_next = payload_reg;
        pri_next     = pri_reg;
        unique case (ctrl.cmd)
            tcps_pkg::CELL_HOLD:
            begin
            end
            tcps_pkg::CELL_PUSH:
            begin
                if (ctrl.at_fill)
                begin
                    key_next     = new_key;
                    payload_next = new_payload;
                    pri_next     = new_pri;
                end
            end
            tcps_pkg::CELL_INSERT:
            begin
                // The new entry lands just above the highest ordinary entry;
                // everything above that point moves up one slot.
                if (!ctrl.sfx_self && ctrl.sfx_below)
                begin
                    key_next     = new_key;
                    payload_next = new_payload;
                    pri_next     = new_pri;
                end
                else if (!ctrl.sfx_below && ctrl.low_occ)
                begin
                    key_next     = below_key;
                    payload_next = below_payload;
                    pri_next     = below_pri;
                end
            end
            tcps_pkg::CELL_SHIFT_DOWN:
            begin
                key_next     = above_key;
                payload_next = above_payload;
                pri_next     = above_pri;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        key_reg     <= key_next;
        payload_reg <= payload_next;
        pri_reg     <= pri_next;
    end

    assign key     = key_reg;
    assign payload = payload_reg;
    assign pri     = pri_reg;
    assign np      = ctrl.occ & ~pri_reg;
    assign hit     = ctrl.occ & (key_reg == new_key);

endmodule

// File: rtl/two_class_priority_stack.sv
// Top level of the two-class priority stack: control, cell row and result register.
//
//  channel | handshake              | payload
//  --------+------------------------+---------------------------------------------
//  in      | in_valid / in_ready    | op, key_in, payload_in, priority_in, drop_count
//  out     | out_valid / out_ready  | top_key, top_payload, top_priority, bottom_key,
//          |                        | occupancy, is_empty, key_found, overflow
//
// All cells load, shift or hold in parallel and the result is registered, so one
// request is taken per cycle unless a pending result is stalled by out_ready low.
// A new request is taken in the same cycle that the pending result is taken.
// Reset empties the stack at once; slot contents are not cleared.
// A stalled result holds the stack and the result register unchanged.
`timescale 1ns / 1ps
`include "two_class_priority_stack_defines.svh"
module two_class_priority_stack #(
    parameter int DEPTH         = tcps_pkg::DEPTH_DEF,
    parameter int KEY_WIDTH     = tcps_pkg::KEY_WIDTH_DEF,
    parameter int PAYLOAD_WIDTH = tcps_pkg::PAYLOAD_WIDTH_DEF,
    localparam int FILL_W       = $clog2(DEPTH + 1)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [tcps_pkg::OP_W-1:0]  op,
    input  logic [KEY_WIDTH-1:0]       key_in,
    input  logic [PAYLOAD_WIDTH-1:0]   payload_in,
    input  logic                       priority_in,
    input  logic [tcps_pkg::DROP_W-1:0] drop_count,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [KEY_WIDTH-1:0]       top_key,
    output logic [PAYLOAD_WIDTH-1:0]   top_payload,
    output logic                       top_priority,
    output logic [KEY_WIDTH-1:0]       bottom_key,
    output logic [FILL_W-1:0]          occupancy,
    output logic                       is_empty,
    output logic                       key_found,
    output logic                       overflow
);

    localparam int CMP_W = (FILL_W > tcps_pkg::DROP_W) ? FILL_W : tcps_pkg::DROP_W;

    logic [FILL_W-1:0]        fill_reg;
    logic [FILL_W-1:0]        fill_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic [KEY_WIDTH-1:0]     out_top_key_reg;
    logic [PAYLOAD_WIDTH-1:0] out_top_payload_reg;
    logic                     out_top_pri_reg;
    logic [KEY_WIDTH-1:0]     out_bottom_key_reg;
    logic [FILL_W-1:0]        out_occ_reg;
    logic                     out_empty_reg;
    logic                     out_found_reg;
    logic                     out_overflow_reg;

    logic                     in_fire;
    logic                     full;
    logic                     over;
    tcps_pkg::cell_cmd_t      cmd;
    logic [CMP_W-1:0]         cnt_ext;
    logic [CMP_W-1:0]         fill_ext;

    logic [KEY_WIDTH-1:0]     c_key          [DEPTH];
    logic [PAYLOAD_WIDTH-1:0] c_payload      [DEPTH];
    logic                     c_pri          [DEPTH];
    logic [KEY_WIDTH-1:0]     c_key_next     [DEPTH];
    logic [PAYLOAD_WIDTH-1:0] c_payload_next [DEPTH];
    logic                     c_pri_next     [DEPTH];
    logic [DEPTH-1:0]         np_vec;
    logic [DEPTH-1:0]         hit_vec;

    logic [KEY_WIDTH-1:0]     sel_key;
    logic [PAYLOAD_WIDTH-1:0] sel_payload;
    logic                     sel_pri;

    assign in_fire  = in_valid & in_ready;
    assign in_ready = ~out_valid_reg | out_ready;
    assign full     = (fill_reg == FILL_W'(DEPTH));
    assign cnt_ext  = CMP_W'(drop_count);
    assign fill_ext = CMP_W'(fill_reg);

    // Request decode: new fill level, the command broadcast to the cells and the flags.
    always_comb
    begin
        fill_next = fill_reg;
        cmd       = tcps_pkg::CELL_HOLD;
        over      = 1'b0;
        if (in_fire)
        begin
            unique case (tcps_pkg::op_e_t'(op))
                tcps_pkg::OP_PUSH:
                begin
                    if (full)
                    begin
                        over = 1'b1;
                    end
                    else
                    begin
                        cmd       = tcps_pkg::CELL_PUSH;
                        fill_next = fill_reg + FILL_W'(1);
                    end
                end
                tcps_pkg::OP_CLASS_PUSH:
                begin
                    if (full)
                    begin
                        over = 1'b1;
                    end
                    else
                    begin
                        cmd = (fill_reg == '0 || priority_in) ? tcps_pkg::CELL_PUSH
                                                             : tcps_pkg::CELL_INSERT;
                        fill_next = fill_reg + FILL_W'(1);
                    end
                end
                tcps_pkg::OP_POP:
                begin
                    if (fill_reg != '0)
                    begin
                        fill_next = fill_reg - FILL_W'(1);
                    end
                end
                tcps_pkg::OP_DROP_BOTTOM:
                begin
                    if (fill_reg != '0)
                    begin
                        cmd       = tcps_pkg::CELL_SHIFT_DOWN;
                        fill_next = fill_reg - FILL_W'(1);
                    end
                end
                tcps_pkg::OP_DROP_COUNT:
                begin
                    fill_next = (cnt_ext >= fill_ext) ? '0 : FILL_W'(fill_ext - cnt_ext);
                end
                tcps_pkg::OP_FIND:
                begin
                end
                default:
                begin
                end
            endcase
        end
    end

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            tcps_pkg::cell_ctrl_t     ctrl;
            logic [KEY_WIDTH-1:0]     below_key;
            logic [PAYLOAD_WIDTH-1:0] below_payload;
            logic                     below_pri;
            logic [KEY_WIDTH-1:0]     above_key;
            logic [PAYLOAD_WIDTH-1:0] above_payload;
            logic                     above_pri;

            assign ctrl.cmd      = cmd;
            assign ctrl.occ      = (fill_reg > FILL_W'(i));
            assign ctrl.at_fill  = (fill_reg == FILL_W'(i));
            assign ctrl.sfx_self = |(np_vec >> i);

            if (i == 0)
            begin : g_bottom
                assign ctrl.low_occ   = 1'b0;
                assign ctrl.sfx_below = 1'b1;
                assign below_key      = '0;
                assign below_payload  = '0;
                assign below_pri      = 1'b0;
            end
            else
            begin : g_inner_low
                assign ctrl.low_occ   = (fill_reg > FILL_W'(i - 1));
                assign ctrl.sfx_below = |(np_vec >> (i - 1));
                assign below_key      = c_key[i-1];
                assign below_payload  = c_payload[i-1];
                assign below_pri      = c_pri[i-1];
            end

            if (i == DEPTH - 1)
            begin : g_top
                assign above_key     = '0;
                assign above_payload = '0;
                assign above_pri     = 1'b0;
            end
            else
            begin : g_inner_high
                assign above_key     = c_key[i+1];
                assign above_payload = c_payload[i+1];
                assign above_pri     = c_pri[i+1];
            end

            tcps_cell #(
                .KEY_WIDTH     (KEY_WIDTH),
                .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
            ) u_cell (
                .clk           (clk),
                .ctrl          (ctrl),
                .new_key       (key_in),
                .new_payload   (payload_in),
                .new_pri       (priority_in),
                .below_key     (below_key),
                .below_payload (below_payload),
                .below_pri     (below_pri),
                .above_key     (above_key),
                .above_payload (above_payload),
                .above_pri     (above_pri),
                .key           (c_key[i]),
                .payload       (c_payload[i]),
                .pri           (c_pri[i]),
                .key_next      (c_key_next[i]),
                .payload_next  (c_payload_next[i]),
                .pri_next      (c_pri_next[i]),
                .np            (np_vec[i]),
                .hit           (hit_vec[i])
            );
        end
    endgenerate

    // The top entry after the request is the cell just below the new fill level.
    always_comb
    begin
        sel_key     = '0;
        sel_payload = '0;
        sel_pri     = 1'b0;
        for (int k = 0; k < DEPTH; k++)
        begin
            if (fill_next == FILL_W'(k + 1))
            begin
                sel_key     = sel_key | c_key_next[k];
                sel_payload = sel_payload | c_payload_next[k];
                sel_pri     = sel_pri | c_pri_next[k];
            end
        end
    end

    always_comb
    begin
        if (in_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            out_top_key_reg     <= sel_key;
            out_top_payload_reg <= sel_payload;
            out_top_pri_reg     <= sel_pri;
            out_bottom_key_reg  <= (fill_next != '0) ? c_key_next[0] : '0;
            out_occ_reg         <= fill_next;
            out_empty_reg       <= (fill_next == '0);
            out_found_reg       <= (tcps_pkg::op_e_t'(op) == tcps_pkg::OP_FIND) & (|hit_vec);
            out_overflow_reg    <= over;
        end
    end

    assign out_valid    = out_valid_reg;
    assign top_key      = out_top_key_reg;
    assign top_payload  = out_top_payload_reg;
    assign top_priority = out_top_pri_reg;
    assign bottom_key   = out_bottom_key_reg;
    assign occupancy    = out_occ_reg;
    assign is_empty     = out_empty_reg;
    assign key_found    = out_found_reg;
    assign overflow     = out_overflow_reg;

    `TCPS_ASSERT_ALWAYS(a_fill_bound, !rst_n || (fill_reg <= FILL_W'(DEPTH)), "fill level beyond depth")
    `TCPS_ASSERT(a_idle_holds, !in_fire |=> $stable(fill_reg), "stack changed without a request")
    `TCPS_ASSERT(a_result_matches, out_valid_reg |-> (out_occ_reg == fill_reg), "result occupancy differs from stack")
    `TCPS_ASSERT(a_overflow_full, (out_valid_reg && out_overflow_reg) |-> (fill_reg == FILL_W'(DEPTH)), "overflow flagged on a stack that is not full")
    `TCPS_ASSERT(a_found_nonempty, (out_valid_reg && out_found_reg) |-> !out_empty_reg, "key found in an empty stack")

endmodule

// File: dv/two_class_priority_stack_tb.sv
// Self-checking testbench for the two-class priority stack.
`timescale 1ns / 1ps
module two_class_priority_stack_tb;

    localparam int DEPTH      = tcps_pkg::DEPTH_DEF;
    localparam int KEY_W      = tcps_pkg::KEY_WIDTH_DEF;
    localparam int PAY_W      = tcps_pkg::PAYLOAD_WIDTH_DEF;
    localparam int OP_W       = tcps_pkg::OP_W;
    localparam int DROP_W     = tcps_pkg::DROP_W;
    localparam int FILL_W     = $clog2(DEPTH + 1);
    localparam int IDLE_LIMIT = 4000;
    localparam int TAIL_WAIT  = 5;

    // Op codes the block leaves undefined; they must report the stack unchanged.
    localparam logic [OP_W-1:0] OP_RSVD_LO = 3'd6;
    localparam logic [OP_W-1:0] OP_RSVD_HI = 3'd7;

    typedef struct packed {
        logic [KEY_W-1:0]  top_key;
        logic [PAY_W-1:0]  top_payload;
        logic              top_priority;
        logic [KEY_W-1:0]  bottom_key;
        logic [FILL_W-1:0] occupancy;
        logic              is_empty;
        logic              key_found;
        logic              overflow;
    } stack_view_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic [OP_W-1:0]   op = tcps_pkg::OP_PUSH;
    logic [KEY_W-1:0]  key_in = '0;
    logic [PAY_W-1:0]  payload_in = '0;
    logic              priority_in = 1'b0;
    logic [DROP_W-1:0] drop_count = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [KEY_W-1:0]  top_key;
    logic [PAY_W-1:0]  top_payload;
    logic              top_priority;
    logic [KEY_W-1:0]  bottom_key;
    logic [FILL_W-1:0] occupancy;
    logic              is_empty;
    logic              key_found;
    logic              overflow;

    // Shadow copy of the stack contents; slot 0 is the bottom.
    logic [KEY_W-1:0] shadow_key [DEPTH];
    logic [PAY_W-1:0] shadow_pay [DEPTH];
    logic             shadow_pri [DEPTH];
    int               shadow_fill = 0;

    stack_view_t expected_views[$];
    int          mismatch_cnt = 0;
    int          idle_cycles = 0;
    int          send_idle_pct = 23;
    int          recv_idle_pct = 73;

    two_class_priority_stack u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .op          (op),
        .key_in      (key_in),
        .payload_in  (payload_in),
        .priority_in (priority_in),
        .drop_count  (drop_count),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .top_key     (top_key),
        .top_payload (top_payload),
        .top_priority(top_priority),
        .bottom_key  (bottom_key),
        .occupancy   (occupancy),
        .is_empty    (is_empty),
        .key_found   (key_found),
        .overflow    (overflow)
    );

    always #5 clk = ~clk;

    // Apply one request to the shadow stack and return the view it should produce.
    function automatic stack_view_t predict_request(input logic [OP_W-1:0] code,
                                                    input logic [KEY_W-1:0] key,
                                                    input logic [PAY_W-1:0] pay,
                                                    input logic pri,
                                                    input logic [DROP_W-1:0] cnt);
        stack_view_t v;
        int          pos;
        v = '0;
        case (code) inside
            tcps_pkg::OP_PUSH, tcps_pkg::OP_CLASS_PUSH:
            begin
                if (shadow_fill >= DEPTH)
                begin
                    v.overflow = 1'b1;
                end
                else
                begin
                    pos = shadow_fill;
                    // An ordinary class push slides under the priority run at the top.
                    if (code == tcps_pkg::OP_CLASS_PUSH && !pri)
                    begin
                        while (pos > 0 && shadow_pri[pos-1])
                            pos--;
                    end
                    for (int i = shadow_fill; i > pos; i--)
                    begin
                        shadow_key[i] = shadow_key[i-1];
                        shadow_pay[i] = shadow_pay[i-1];
                        shadow_pri[i] = shadow_pri[i-1];
                    end
                    shadow_key[pos] = key;
                    shadow_pay[pos] = pay;
                    shadow_pri[pos] = pri;
                    shadow_fill++;
                end
            end
            tcps_pkg::OP_POP:
            begin
                if (shadow_fill > 0)
                    shadow_fill--;
            end
            tcps_pkg::OP_DROP_BOTTOM:
            begin
                if (shadow_fill > 0)
                begin
                    for (int i = 1; i < shadow_fill; i++)
                    begin
                        shadow_key[i-1] = shadow_key[i];
                        shadow_pay[i-1] = shadow_pay[i];
                        shadow_pri[i-1] = shadow_pri[i];
                    end
                    shadow_fill--;
                end
            end
            tcps_pkg::OP_DROP_COUNT:
            begin
                shadow_fill = (int'(cnt) >= shadow_fill) ? 0 : shadow_fill - int'(cnt);
            end
            tcps_pkg::OP_FIND:
            begin
                for (int i = 0; i < shadow_fill; i++)
                    if (shadow_key[i] == key)
                        v.key_found = 1'b1;
            end
            default:
            begin
            end
        endcase
        if (shadow_fill > 0)
        begin
            v.top_key      = shadow_key[shadow_fill-1];
            v.top_payload  = shadow_pay[shadow_fill-1];
            v.top_priority = shadow_pri[shadow_fill-1];
            v.bottom_key   = shadow_key[0];
        end
        v.occupancy = shadow_fill[FILL_W-1:0];
        v.is_empty  = (shadow_fill == 0);
        return v;
    endfunction

    task automatic compare_field(input string name, input logic [31:0] exp_v,
                                 input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
            mismatch_cnt++;
        end
    endtask

    // Result checker and receiver stall generator.
    always @(posedge clk)
    begin
        stack_view_t exp_v;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_views.size() == 0)
            begin
                $display("%0t: result with no request outstanding, expected none, actual %h",
                         $time, top_key);
                mismatch_cnt++;
            end
            else
            begin
                exp_v = expected_views.pop_front();
                compare_field("top_key", exp_v.top_key, top_key);
                compare_field("top_payload", exp_v.top_payload, top_payload);
                compare_field("top_priority", 32'(exp_v.top_priority), 32'(top_priority));
                compare_field("bottom_key", exp_v.bottom_key, bottom_key);
                compare_field("occupancy", 32'(exp_v.occupancy), 32'(occupancy));
                compare_field("is_empty", 32'(exp_v.is_empty), 32'(is_empty));
                compare_field("key_found", 32'(exp_v.key_found), 32'(key_found));
                compare_field("overflow", 32'(exp_v.overflow), 32'(overflow));
            end
        end
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog: ends the run if no handshake happens for too long.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    // Sends one request; returns in the time step of its acceptance with valid still high.
    task automatic issue_request(input logic [OP_W-1:0] code, input logic [KEY_W-1:0] key,
                                 input logic [PAY_W-1:0] pay, input logic pri,
                                 input logic [DROP_W-1:0] cnt);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_valid    <= 1'b1;
        op          <= code;
        key_in      <= key;
        payload_in  <= pay;
        priority_in <= pri;
        drop_count  <= cnt;
        do
            @(posedge clk);
        while (!in_ready);
        expected_views.push_back(predict_request(code, key, pay, pri, cnt));
    endtask

    // Sender holds off until every outstanding result has been taken.
    task automatic hold_until_drained();
        in_valid <= 1'b0;
        while (expected_views.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_empty_stack();
        issue_request(tcps_pkg::OP_POP, '1, '1, 1'b1, '1);
        issue_request(tcps_pkg::OP_DROP_BOTTOM, '0, '0, 1'b0, '0);
        issue_request(tcps_pkg::OP_DROP_COUNT, 32'h1234_5678, '0, 1'b0, '0);
        issue_request(tcps_pkg::OP_DROP_COUNT, '0, '1, 1'b1, '1);
        issue_request(tcps_pkg::OP_FIND, '0, '0, 1'b0, '0);
        issue_request(OP_RSVD_LO, '1, '1, 1'b1, 5'd3);
        issue_request(OP_RSVD_HI, '0, '0, 1'b0, 5'd16);
    endtask

    task automatic test_class_insert();
        // An ordinary entry pushed onto an empty stack goes on top.
        issue_request(tcps_pkg::OP_CLASS_PUSH, '0, '1, 1'b0, '0);
        issue_request(tcps_pkg::OP_CLASS_PUSH, '1, '0, 1'b1, '0);
        issue_request(tcps_pkg::OP_CLASS_PUSH, 32'hA5A5_0001, 32'h0000_00A1, 1'b1, '0);
        // Lands beneath the two priority entries.
        issue_request(tcps_pkg::OP_CLASS_PUSH, 32'hB0B0_0002, 32'h0000_00B2, 1'b0, '0);
        issue_request(tcps_pkg::OP_PUSH, 32'hC3C3_0003, 32'h0000_00C3, 1'b0, '0);
        // Top is ordinary, so the priority run is empty and this goes on top.
        issue_request(tcps_pkg::OP_CLASS_PUSH, 32'hD4D4_0004, 32'h0000_00D4, 1'b0, '0);
        issue_request(tcps_pkg::OP_PUSH, 32'h5A5A_0005, 32'h0000_0055, 1'b1, '1);
        issue_request(tcps_pkg::OP_FIND, 32'hB0B0_0002, '0, 1'b0, '0);
        issue_request(tcps_pkg::OP_FIND, 32'hDEAD_BEEF, '1, 1'b1, '1);
        issue_request(tcps_pkg::OP_DROP_BOTTOM, '1, '1, 1'b1, '1);
        issue_request(tcps_pkg::OP_DROP_COUNT, '0, '0, 1'b0, 5'd2);
        issue_request(tcps_pkg::OP_DROP_COUNT, '0, '0, 1'b0, '0);
        issue_request(tcps_pkg::OP_POP, '0, '0, 1'b0, '0);
        issue_request(OP_RSVD_HI, '1, '1, 1'b1, '1);
    endtask

    task automatic test_full_stack();
        issue_request(tcps_pkg::OP_DROP_COUNT, '0, '0, 1'b0, 5'd16);
        for (int i = 0; i < DEPTH; i++)
            issue_request(tcps_pkg::OP_CLASS_PUSH, $urandom, $urandom,
                          1'($urandom_range(1)), '0);
        issue_request(tcps_pkg::OP_PUSH, '1, '1, 1'b1, '0);
        issue_request(tcps_pkg::OP_CLASS_PUSH, 32'h0BAD_0BAD, '0, 1'b0, '0);
        issue_request(tcps_pkg::OP_CLASS_PUSH, 32'h0BAD_0BAE, '1, 1'b1, '0);
        issue_request(tcps_pkg::OP_FIND, shadow_key[DEPTH/2], '0, 1'b0, '0);
        issue_request(tcps_pkg::OP_DROP_BOTTOM, '0, '0, 1'b0, '0);
        issue_request(tcps_pkg::OP_DROP_COUNT, '0, '0, 1'b0, 5'd16);
    endtask

    // Random requests that sweep the stack between empty and full.
    task automatic test_random(input int snd_pct, input int rcv_pct, input int n_req);
        logic [OP_W-1:0]   code;
        logic [KEY_W-1:0]  key;
        logic [DROP_W-1:0] cnt;
        int                r;
        bit                grow;
        send_idle_pct = snd_pct;
        recv_idle_pct = rcv_pct;
        grow = 1'b1;
        for (int n = 0; n < n_req; n++)
        begin
            if (shadow_fill == 0)
                grow = 1'b1;
            else if (shadow_fill == DEPTH && $urandom_range(3) == 0)
                grow = 1'b0;
            else if ($urandom_range(63) == 0)
                grow = ~grow;
            r = $urandom_range(99);
            if (grow)
                code = (r < 30) ? tcps_pkg::OP_PUSH : (r < 60) ? tcps_pkg::OP_CLASS_PUSH :
                       (r < 70) ? tcps_pkg::OP_POP : (r < 75) ? tcps_pkg::OP_DROP_BOTTOM :
                       (r < 80) ? tcps_pkg::OP_DROP_COUNT : (r < 96) ? tcps_pkg::OP_FIND :
                       (r < 98) ? OP_RSVD_LO : OP_RSVD_HI;
            else
                code = (r < 10) ? tcps_pkg::OP_PUSH : (r < 20) ? tcps_pkg::OP_CLASS_PUSH :
                       (r < 45) ? tcps_pkg::OP_POP : (r < 65) ? tcps_pkg::OP_DROP_BOTTOM :
                       (r < 80) ? tcps_pkg::OP_DROP_COUNT : (r < 96) ? tcps_pkg::OP_FIND :
                       (r < 98) ? OP_RSVD_LO : OP_RSVD_HI;
            // A small key pool makes duplicate keys and find hits common.
            key = ($urandom_range(1) == 0) ? KEY_W'(32'h100 + $urandom_range(7)) : $urandom;
            if (code == tcps_pkg::OP_FIND && shadow_fill > 0 && $urandom_range(1) == 0)
                key = shadow_key[$urandom_range(shadow_fill - 1)];
            cnt = ($urandom_range(3) == 0) ? DROP_W'($urandom_range(31))
                                           : DROP_W'($urandom_range(3));
            issue_request(code, key, $urandom, 1'($urandom_range(1)), cnt);
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_stack();
        test_class_insert();
        test_full_stack();
        hold_until_drained();
        test_random(23, 73, 470);
        hold_until_drained();
        test_random(73, 23, 470);
        hold_until_drained();
        test_random(0, 0, 470);
        in_valid <= 1'b0;
        while (expected_views.size() != 0)
            @(posedge clk);
        repeat (TAIL_WAIT) @(posedge clk);
        if (mismatch_cnt == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
